// ----- rtl/vrt_pkg.sv -----
package vrt_pkg;

	localparam int FX_W    = 24;
	localparam int FRAC_W  = 12;
	localparam int ONE_FX  = 4096;
	localparam int CUR_W   = 13;
	localparam int VOX_W   = 12;
	localparam int CELL_W  = 5;
	localparam int D_W     = 25;
	localparam int AD_W    = 24;
	localparam int SQ_W    = 33;
	localparam int S_W     = 50;
	localparam int TG_W    = 26;
	localparam int NT_W    = 27;
	localparam int MA_W    = 34;
	localparam int MB_W    = 28;
	localparam int PR_W    = MA_W + MB_W;
	localparam int QD_W    = 51;
	localparam int SUM_W   = 54;
	localparam int MARGIN_XZ = 410;
	localparam int MARGIN_Y  = 164;
	localparam int PAR_LIMIT = 67109;
	localparam int PAR_SQ    = 1000000;
	localparam int SETUP_LEN = 15;
	localparam int SETUP_CW  = 4;

	// input transaction kinds
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	// micro-op codes for the shared multiplier / setup sequence
	localparam logic [2:0] OP_NONE  = 3'd0;
	localparam logic [2:0] OP_SQ    = 3'd1;
	localparam logic [2:0] OP_SM    = 3'd2;
	localparam logic [2:0] OP_FIX   = 3'd3;
	localparam logic [2:0] OP_CROSS = 3'd4;
	localparam logic [2:0] OP_EXIT  = 3'd5;

	typedef struct packed {
		logic [2:0] op;
		logic [2:0] sel;
	} vrt_uop_t;

	typedef struct packed {
		logic     clr;
		logic     wr;
		logic     load;
		logic     init;
		vrt_uop_t uop;
		logic     step;
		logic     ex_prep;
		logic     ex_div;
		logic     ex_store;
		logic     ex_sel;
		logic     out_load;
		logic     res_hit;
		logic     res_trunc;
	} vrt_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic all_done;
		logic occ;
		logic div_done;
		logic out_busy;
	} vrt_stat_t;

	// setup program: squares, parallel tests, distance init, cross products
	function automatic vrt_uop_t setup_uop(input logic [SETUP_CW-1:0] idx);
		vrt_uop_t u;
		u.op  = OP_NONE;
		u.sel = 3'd0;
		case (idx)
			4'd0: begin u.op = OP_SQ; u.sel = 3'd0; end
			4'd1: begin u.op = OP_SQ; u.sel = 3'd1; end
			4'd2: begin u.op = OP_SQ; u.sel = 3'd2; end
			4'd3: begin u.op = OP_SM; u.sel = 3'd0; end
			4'd4: begin u.op = OP_SM; u.sel = 3'd1; end
			4'd5: begin u.op = OP_SM; u.sel = 3'd2; end
			4'd7: begin u.op = OP_FIX; end
			4'd8: begin u.op = OP_CROSS; u.sel = 3'd0; end
			4'd9: begin u.op = OP_CROSS; u.sel = 3'd1; end
			4'd10: begin u.op = OP_CROSS; u.sel = 3'd2; end
			4'd11: begin u.op = OP_CROSS; u.sel = 3'd3; end
			4'd12: begin u.op = OP_CROSS; u.sel = 3'd4; end
			4'd13: begin u.op = OP_CROSS; u.sel = 3'd5; end
			default: begin u.op = OP_NONE; end
		endcase
		return u;
	endfunction

	// cross product c = num[pair_i] * den[pair_j]
	function automatic logic [1:0] pair_i(input logic [2:0] c);
		logic [1:0] r;
		case (c)
			3'd0, 3'd2: r = 2'd0;
			3'd1, 3'd4: r = 2'd1;
			default:    r = 2'd2;
		endcase
		return r;
	endfunction

	function automatic logic [1:0] pair_j(input logic [2:0] c);
		logic [1:0] r;
		case (c)
			3'd1, 3'd3: r = 2'd0;
			3'd0, 3'd5: r = 2'd1;
			default:    r = 2'd2;
		endcase
		return r;
	endfunction

	// the two axes other than the hit axis, in order
	function automatic logic [1:0] other_axis(input logic [1:0] axis, input logic j);
		logic [1:0] r;
		if (!j) begin
			r = (axis == 2'd0) ? 2'd1 : 2'd0;
		end else begin
			r = (axis == 2'd2) ? 2'd1 : 2'd2;
		end
		return r;
	endfunction

endpackage

// ----- rtl/voxel_ray_traversal_unit.sv -----
// Voxel ray traversal unit.
// Input channel (in_valid/in_ready): op=0 is a voxel write (cell_x/y/z, solid),
// with no result. op=1 is a ray query (start_*, end_*, signed
// 12.12 fixed point); it gives exactly one result transaction on the output
// channel (out_valid/out_ready): hit, truncated, last voxel, face, exit point.
// Query sequence: load and init, a setup program on the shared multiplier,
// then a decide and an occupancy read per voxel step. A walk that ends
// without a hit takes one more decide and then finishes. A hit adds the two
// exit coordinates, each computed by the bit-serial divider, then finishes.
// Queries run one at a time; in_ready is high only when the unit is idle,
// so throughput equals latency.
// After reset the occupancy memory is cleared one entry per cycle
// (2^(3*clog2(GRID_EDGE)) entries, 32768 at the default); in_ready stays low.
// The result sits in an output register: a stalled receiver blocks only the
// delivery of the next query's result, and the unit can take writes and a
// new query while a result waits.
module voxel_ray_traversal_unit import vrt_pkg::*; #(
	parameter int GRID_EDGE = 32,
	parameter int MAX_STEPS = 128
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic                    op,
	input  logic [CELL_W-1:0]       cell_x,
	input  logic [CELL_W-1:0]       cell_y,
	input  logic [CELL_W-1:0]       cell_z,
	input  logic                    solid,
	input  logic signed [FX_W-1:0]  start_x,
	input  logic signed [FX_W-1:0]  start_y,
	input  logic signed [FX_W-1:0]  start_z,
	input  logic signed [FX_W-1:0]  end_x,
	input  logic signed [FX_W-1:0]  end_y,
	input  logic signed [FX_W-1:0]  end_z,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic                    hit,
	output logic                    truncated,
	output logic signed [VOX_W-1:0] voxel_x,
	output logic signed [VOX_W-1:0] voxel_y,
	output logic signed [VOX_W-1:0] voxel_z,
	output logic [2:0]              face,
	output logic signed [FX_W-1:0]  exit_x,
	output logic signed [FX_W-1:0]  exit_y,
	output logic signed [FX_W-1:0]  exit_z
);
	vrt_cmd_t  cmd;   // sequencer -> datapath
	vrt_stat_t st;    // datapath -> sequencer

	// sequencer: clear pass, setup program, walk loop, exit computation
	vrt_ctrl #(.MAX_STEPS(MAX_STEPS)) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.op       (op),
		.st       (st),
		.cmd      (cmd)
	);

	// datapath: occupancy memory, boundary cross products, multiplier, divider
	vrt_dpath #(.GRID_EDGE(GRID_EDGE), .MAX_STEPS(MAX_STEPS)) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.st        (st),
		.out_ready (out_ready),
		.cell_x    (cell_x),
		.cell_y    (cell_y),
		.cell_z    (cell_z),
		.solid     (solid),
		.start_x   (start_x),
		.start_y   (start_y),
		.start_z   (start_z),
		.end_x     (end_x),
		.end_y     (end_y),
		.end_z     (end_z),
		.out_valid (out_valid),
		.hit       (hit),
		.truncated (truncated),
		.voxel_x   (voxel_x),
		.voxel_y   (voxel_y),
		.voxel_z   (voxel_z),
		.face      (face),
		.exit_x    (exit_x),
		.exit_y    (exit_y),
		.exit_z    (exit_z)
	);

	// a step must not follow a step directly; it waits for its occupancy read
	a_step_spacing: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |=> !cmd.step)
		else $error("back-to-back walk steps");

	// never overwrite a result the receiver has not taken
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !(out_valid && !out_ready))
		else $error("result register overwritten");

	// memory writes only from an accepted write transaction
	a_write_accept: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr |-> (in_valid && in_ready && (op == OP_WRITE)))
		else $error("voxel write without accepted transaction");

	a_cmd_excl: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.clr, cmd.load, cmd.step, cmd.ex_store, cmd.out_load}))
		else $error("conflicting datapath commands");

endmodule

// ----- rtl/vrt_div.sv -----
module vrt_div import vrt_pkg::*; #(
	parameter int DW = 51,
	parameter int VW = 24
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [VW-1:0] divisor,
	output logic          done,
	output logic [DW-1:0] quot,
	output logic [VW-1:0] rem
);
	localparam int CNT_W = $clog2(DW + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DW-1:0]    quo_q;
	logic [VW-1:0]    rem_q;
	logic [VW-1:0]    dvs_q;
	logic [VW:0]      rem_sh;
	logic [VW:0]      rem_sub;
	logic             ge;

	assign rem_sh  = {rem_q, quo_q[DW-1]};
	assign ge      = rem_sh >= {1'b0, dvs_q};
	assign rem_sub = rem_sh - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// restoring division, one quotient bit per cycle
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DW-2:0], ge};
			rem_q <= ge ? rem_sub[VW-1:0] : rem_sh[VW-1:0];
		end
	end

	assign done = done_q;
	assign quot = quo_q;
	assign rem  = rem_q;

endmodule

// ----- rtl/vrt_dpath.sv -----
module vrt_dpath import vrt_pkg::*; #(
	parameter int GRID_EDGE = 32,
	parameter int MAX_STEPS = 128
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  vrt_cmd_t                cmd,
	output vrt_stat_t               st,
	input  logic                    out_ready,
	input  logic [CELL_W-1:0]       cell_x,
	input  logic [CELL_W-1:0]       cell_y,
	input  logic [CELL_W-1:0]       cell_z,
	input  logic                    solid,
	input  logic signed [FX_W-1:0]  start_x,
	input  logic signed [FX_W-1:0]  start_y,
	input  logic signed [FX_W-1:0]  start_z,
	input  logic signed [FX_W-1:0]  end_x,
	input  logic signed [FX_W-1:0]  end_y,
	input  logic signed [FX_W-1:0]  end_z,
	output logic                    out_valid,
	output logic                    hit,
	output logic                    truncated,
	output logic signed [VOX_W-1:0] voxel_x,
	output logic signed [VOX_W-1:0] voxel_y,
	output logic signed [VOX_W-1:0] voxel_z,
	output logic [2:0]              face,
	output logic signed [FX_W-1:0]  exit_x,
	output logic signed [FX_W-1:0]  exit_y,
	output logic signed [FX_W-1:0]  exit_z
);
	localparam int CW    = $clog2(GRID_EDGE);
	localparam int AW    = 3 * CW;
	localparam int DEPTH = 1 << AW;
	localparam int NW    = $clog2(ONE_FX * (MAX_STEPS + 1) + 1);
	localparam int PW    = NW + AD_W;
	localparam int CMPW  = (NW > AD_W) ? NW : AD_W;
	localparam logic signed [SUM_W-1:0] FX_MAX = SUM_W'(8388607);
	localparam logic signed [SUM_W-1:0] FX_MIN = -SUM_W'(8388608);

	function automatic logic signed [FX_W-1:0] sat_fx(input logic signed [SUM_W-1:0] v);
		logic signed [SUM_W-1:0] r;
		r = v;
		if (v > FX_MAX) r = FX_MAX;
		if (v < FX_MIN) r = FX_MIN;
		return r[FX_W-1:0];
	endfunction

	function automatic logic in_grid(input logic signed [CUR_W-1:0] c);
		return !c[CUR_W-1] && (c < CUR_W'(GRID_EDGE));
	endfunction

	// query operands
	logic signed [FX_W-1:0]  s_q   [3];
	logic signed [FX_W-1:0]  e_q   [3];
	logic signed [D_W-1:0]   d_q   [3];
	logic [AD_W-1:0]         ad_q  [3];
	logic                    pos_q [3];
	logic signed [CUR_W-1:0] cur_q [3];
	logic signed [CUR_W-1:0] cur_n [3];
	logic [SQ_W-1:0]         sq_q  [3];
	logic [S_W-1:0]          ssum_q;
	logic                    small_q [3];
	logic [NW-1:0]           num_q [3];
	logic [AD_W-1:0]         den_q [3];
	logic [PW-1:0]           p_q   [6];
	logic signed [FX_W-1:0]  ex_q  [3];
	logic [1:0]              axis_q;
	logic signed [NT_W-1:0]  nt_q;
	logic                    neg_q;

	// shared multiplier
	logic signed [MA_W-1:0]  ma;
	logic signed [MB_W-1:0]  mb;
	logic signed [PR_W-1:0]  prod_s1;
	logic [2:0]              op_s1;
	logic [2:0]              sel_s1;
	logic [1:0]              isel;
	logic [1:0]              jsel;
	logic [1:0]              bsel;

	// occupancy memory
	logic                    occ_mem_q [DEPTH];
	logic                    rd_q;
	logic                    inb_q;
	logic [AW-1:0]           clr_addr_q;
	logic [AW-1:0]           rd_addr;
	logic [AW-1:0]           wr_addr;
	logic                    mem_we;
	logic                    mem_wd;
	logic [AW-1:0]           mem_wa;
	logic signed [CUR_W-1:0] wcx, wcy, wcz;
	logic                    wr_in;

	// walk decision
	logic                    l01, l02, l12;
	logic [1:0]              k_sel;
	logic                    all_done_c;

	// exit point
	logic signed [TG_W-1:0]  tgt_c;
	logic signed [NT_W-1:0]  nt_c;
	logic signed [SUM_W-1:0] mg;
	logic signed [SUM_W-1:0] hx;
	logic [PR_W-1:0]         prod_abs;
	logic                    div_done;
	logic [QD_W-1:0]         div_q;
	logic [AD_W-1:0]         div_r;
	logic [QD_W:0]           qr;
	logic signed [SUM_W-1:0] qs;
	logic signed [SUM_W-1:0] ex_sum;

	logic                    out_valid_q;
	logic                    hit_q, trunc_q;
	logic signed [VOX_W-1:0] vox_q [3];
	logic [2:0]              face_q;
	logic signed [FX_W-1:0]  exo_q [3];

	// ---- axis choice: smallest boundary fraction, ties go to the higher axis
	assign l01   = p_q[0] < p_q[1];
	assign l02   = p_q[2] < p_q[3];
	assign l12   = p_q[4] < p_q[5];
	assign k_sel = l01 ? (l02 ? 2'd0 : 2'd2) : (l12 ? 2'd1 : 2'd2);

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			cur_n[a] = cur_q[a];
		end
		cur_n[k_sel] = pos_q[k_sel] ? (cur_q[k_sel] + CUR_W'(1)) : (cur_q[k_sel] - CUR_W'(1));
	end

	assign rd_addr = {cur_n[2][CW-1:0], cur_n[1][CW-1:0], cur_n[0][CW-1:0]};

	// ---- voxel write port
	assign wcx     = CUR_W'(cell_x);
	assign wcy     = CUR_W'(cell_y);
	assign wcz     = CUR_W'(cell_z);
	assign wr_in   = in_grid(wcx) && in_grid(wcy) && in_grid(wcz);
	assign wr_addr = {wcz[CW-1:0], wcy[CW-1:0], wcx[CW-1:0]};
	assign mem_we  = cmd.clr || (cmd.wr && wr_in);
	assign mem_wd  = cmd.clr ? 1'b0 : solid;
	assign mem_wa  = cmd.clr ? clr_addr_q : wr_addr;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			occ_mem_q[mem_wa] <= mem_wd;
		end
		rd_q <= occ_mem_q[rd_addr];
	end

	// ---- multiplier operand select
	assign isel = pair_i(cmd.uop.sel);
	assign jsel = pair_j(cmd.uop.sel);
	assign bsel = other_axis(axis_q, cmd.uop.sel[0]);

	always_comb begin
		ma = '0;
		mb = '0;
		case (cmd.uop.op)
			OP_SQ: begin
				ma = MA_W'(ad_q[cmd.uop.sel[1:0]]);
				mb = MB_W'(ad_q[cmd.uop.sel[1:0]]);
			end
			OP_SM: begin
				ma = MA_W'(sq_q[cmd.uop.sel[1:0]]);
				mb = MB_W'(PAR_SQ);
			end
			OP_CROSS: begin
				ma = MA_W'(num_q[isel]);
				mb = MB_W'(den_q[jsel]);
			end
			OP_EXIT: begin
				ma = MA_W'(d_q[bsel]);
				mb = MB_W'(nt_q);
			end
			default: begin
				ma = '0;
				mb = '0;
			end
		endcase
	end

	// ---- exit point arithmetic
	assign tgt_c = TG_W'($signed({cur_q[axis_q], {FRAC_W{1'b0}}}))
		+ (pos_q[axis_q] ? TG_W'(0) : TG_W'(ONE_FX));
	assign nt_c  = NT_W'(tgt_c) - NT_W'(s_q[axis_q]);
	assign mg    = (axis_q == 2'd1) ? SUM_W'(MARGIN_Y) : SUM_W'(MARGIN_XZ);
	assign hx    = SUM_W'(tgt_c) + (pos_q[axis_q] ? -mg : mg);

	assign prod_abs = prod_s1[PR_W-1] ? PR_W'(-prod_s1) : PR_W'(prod_s1);

	vrt_div #(.DW(QD_W), .VW(AD_W)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.ex_div),
		.dividend (prod_abs[QD_W-1:0]),
		.divisor  (ad_q[axis_q]),
		.done     (div_done),
		.quot     (div_q),
		.rem      (div_r)
	);

	// round to nearest, ties away from zero
	assign qr     = {1'b0, div_q} + ((({div_r, 1'b0}) >= {1'b0, ad_q[axis_q]}) ? (QD_W+1)'(1)
		: (QD_W+1)'(0));
	assign qs     = neg_q ? -$signed(SUM_W'(qr)) : $signed(SUM_W'(qr));
	assign ex_sum = SUM_W'(s_q[other_axis(axis_q, cmd.ex_sel)]) + qs;

	// ---- control-side registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_s1       <= OP_NONE;
			sel_s1      <= 3'd0;
			clr_addr_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			op_s1  <= cmd.uop.op;
			sel_s1 <= cmd.uop.sel;
			if (cmd.clr) begin
				clr_addr_q <= clr_addr_q + 1'b1;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// ---- payload registers
	always_ff @(posedge clk) begin
		prod_s1 <= ma * mb;

		if (cmd.load) begin
			s_q[0] <= start_x; s_q[1] <= start_y; s_q[2] <= start_z;
			e_q[0] <= end_x;   e_q[1] <= end_y;   e_q[2] <= end_z;
		end

		if (cmd.init) begin
			ssum_q <= '0;
			for (int a = 0; a < 3; a++) begin
				d_q[a]   <= D_W'(e_q[a]) - D_W'(s_q[a]);
				ad_q[a]  <= (e_q[a] < s_q[a]) ? AD_W'(D_W'(s_q[a]) - D_W'(e_q[a]))
					: AD_W'(D_W'(e_q[a]) - D_W'(s_q[a]));
				pos_q[a] <= e_q[a] > s_q[a];
				cur_q[a] <= CUR_W'(s_q[a] >>> FRAC_W);
				ex_q[a]  <= e_q[a];
			end
		end

		// multiplier write-back, in the cycle after issue
		case (op_s1)
			OP_SQ: begin
				ssum_q <= ssum_q + S_W'(prod_s1);
				sq_q[sel_s1[1:0]] <= prod_s1[SQ_W-1:0];
			end
			OP_SM: begin
				small_q[sel_s1[1:0]] <= (ssum_q == '0) ||
					((ad_q[sel_s1[1:0]] < AD_W'(PAR_LIMIT)) &&
					 ($unsigned(prod_s1) < PR_W'(ssum_q)));
			end
			OP_CROSS: begin
				p_q[sel_s1] <= prod_s1[PW-1:0];
			end
			default: begin
			end
		endcase

		if (cmd.uop.op == OP_FIX) begin
			for (int a = 0; a < 3; a++) begin
				if (small_q[a]) begin
					num_q[a] <= NW'(1);
					den_q[a] <= AD_W'(1);
				end else begin
					num_q[a] <= pos_q[a] ? NW'(ONE_FX - int'(s_q[a][FRAC_W-1:0]))
						: NW'(s_q[a][FRAC_W-1:0]);
					den_q[a] <= ad_q[a];
				end
			end
		end

		if (cmd.step) begin
			for (int a = 0; a < 3; a++) begin
				cur_q[a] <= cur_n[a];
			end
			num_q[k_sel] <= num_q[k_sel] + NW'(ONE_FX);
			for (int c = 0; c < 6; c++) begin
				if (pair_i(3'(c)) == k_sel) begin
					p_q[c] <= p_q[c] + (PW'(den_q[pair_j(3'(c))]) << FRAC_W);
				end
			end
			axis_q <= k_sel;
			inb_q  <= in_grid(cur_n[0]) && in_grid(cur_n[1]) && in_grid(cur_n[2]);
		end

		if (cmd.ex_prep) begin
			nt_q         <= nt_c;
			ex_q[axis_q] <= sat_fx(hx);
		end

		if (cmd.ex_div) begin
			neg_q <= prod_s1[PR_W-1] ^ d_q[axis_q][D_W-1];
		end

		if (cmd.ex_store) begin
			ex_q[other_axis(axis_q, cmd.ex_sel)] <= sat_fx(ex_sum);
		end

		if (cmd.out_load) begin
			hit_q   <= cmd.res_hit;
			trunc_q <= cmd.res_trunc;
			face_q  <= cmd.res_hit ? {axis_q, pos_q[axis_q]} : 3'd0;
			for (int a = 0; a < 3; a++) begin
				vox_q[a] <= cur_q[a][VOX_W-1:0];
				exo_q[a] <= ex_q[a];
			end
		end
	end

	// ---- status
	always_comb begin
		all_done_c = 1'b1;
		for (int a = 0; a < 3; a++) begin
			if (CMPW'(num_q[a]) < CMPW'(den_q[a])) all_done_c = 1'b0;
		end
	end
	assign st.all_done = all_done_c;
	assign st.clr_last = &clr_addr_q;
	assign st.occ      = rd_q && inb_q;
	assign st.div_done = div_done;
	assign st.out_busy = out_valid_q && !out_ready;

	assign out_valid = out_valid_q;
	assign hit       = hit_q;
	assign truncated = trunc_q;
	assign voxel_x   = vox_q[0];
	assign voxel_y   = vox_q[1];
	assign voxel_z   = vox_q[2];
	assign face      = face_q;
	assign exit_x    = exo_q[0];
	assign exit_y    = exo_q[1];
	assign exit_z    = exo_q[2];

endmodule

// ----- rtl/vrt_ctrl.sv -----
module vrt_ctrl import vrt_pkg::*; #(
	parameter int MAX_STEPS = 128
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  logic      op,
	input  vrt_stat_t st,
	output vrt_cmd_t  cmd
);
	localparam int SW = $clog2(MAX_STEPS + 1);

	localparam logic [3:0] S_CLEAR  = 4'd0;
	localparam logic [3:0] S_IDLE   = 4'd1;
	localparam logic [3:0] S_INIT   = 4'd2;
	localparam logic [3:0] S_SETUP  = 4'd3;
	localparam logic [3:0] S_DECIDE = 4'd4;
	localparam logic [3:0] S_CHECK  = 4'd5;
	localparam logic [3:0] S_EXPREP = 4'd6;
	localparam logic [3:0] S_EXMUL  = 4'd7;
	localparam logic [3:0] S_EXDIV  = 4'd8;
	localparam logic [3:0] S_EXWAIT = 4'd9;
	localparam logic [3:0] S_FINISH = 4'd10;

	logic [3:0]          state_q, state_d;
	logic [SETUP_CW-1:0] idx_q, idx_d;
	logic [SW-1:0]       step_q, step_d;
	logic                hit_q, hit_d;
	logic                trunc_q, trunc_d;
	logic                j_q, j_d;

	always_comb begin
		state_d = state_q;
		idx_d   = idx_q;
		step_d  = step_q;
		hit_d   = hit_q;
		trunc_d = trunc_q;
		j_d     = j_q;
		cmd     = '0;
		in_ready = (state_q == S_IDLE);
		case (state_q)
			S_CLEAR: begin
				cmd.clr = 1'b1;
				if (st.clr_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) begin
					if (op == OP_QUERY) begin
						cmd.load = 1'b1;
						state_d  = S_INIT;
					end else begin
						cmd.wr = 1'b1;
					end
				end
			end
			S_INIT: begin
				cmd.init = 1'b1;
				idx_d    = '0;
				step_d   = '0;
				hit_d    = 1'b0;
				trunc_d  = 1'b0;
				state_d  = S_SETUP;
			end
			S_SETUP: begin
				cmd.uop = setup_uop(idx_q);
				idx_d   = idx_q + 1'b1;
				if (idx_q == SETUP_CW'(SETUP_LEN - 1)) state_d = S_DECIDE;
			end
			S_DECIDE: begin
				if (st.all_done) begin
					state_d = S_FINISH;
				end else if (step_q == SW'(MAX_STEPS)) begin
					trunc_d = 1'b1;
					state_d = S_FINISH;
				end else begin
					cmd.step = 1'b1;
					step_d   = step_q + 1'b1;
					state_d  = S_CHECK;
				end
			end
			S_CHECK: begin
				if (st.occ) begin
					hit_d   = 1'b1;
					state_d = S_EXPREP;
				end else begin
					state_d = S_DECIDE;
				end
			end
			S_EXPREP: begin
				cmd.ex_prep = 1'b1;
				j_d         = 1'b0;
				state_d     = S_EXMUL;
			end
			S_EXMUL: begin
				cmd.uop.op  = OP_EXIT;
				cmd.uop.sel = {2'b00, j_q};
				state_d     = S_EXDIV;
			end
			S_EXDIV: begin
				cmd.ex_div = 1'b1;
				state_d    = S_EXWAIT;
			end
			S_EXWAIT: begin
				if (st.div_done) begin
					cmd.ex_store = 1'b1;
					cmd.ex_sel   = j_q;
					if (j_q) begin
						state_d = S_FINISH;
					end else begin
						j_d     = 1'b1;
						state_d = S_EXMUL;
					end
				end
			end
			S_FINISH: begin
				if (!st.out_busy) begin
					cmd.out_load  = 1'b1;
					cmd.res_hit   = hit_q;
					cmd.res_trunc = trunc_q;
					state_d       = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			idx_q   <= '0;
			step_q  <= '0;
			hit_q   <= 1'b0;
			trunc_q <= 1'b0;
			j_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			step_q  <= step_d;
			hit_q   <= hit_d;
			trunc_q <= trunc_d;
			j_q     <= j_d;
		end
	end

endmodule

// ----- test/vrt_checker.sv -----
`timescale 1ns / 1ps

module vrt_checker import vrt_pkg::*; #(
	parameter int GRID_EDGE = 32,
	parameter int MAX_STEPS = 128
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	input  logic                    in_ready,
	input  logic                    op,
	input  logic [CELL_W-1:0]       cell_x,
	input  logic [CELL_W-1:0]       cell_y,
	input  logic [CELL_W-1:0]       cell_z,
	input  logic                    solid,
	input  logic signed [FX_W-1:0]  start_x,
	input  logic signed [FX_W-1:0]  start_y,
	input  logic signed [FX_W-1:0]  start_z,
	input  logic signed [FX_W-1:0]  end_x,
	input  logic signed [FX_W-1:0]  end_y,
	input  logic signed [FX_W-1:0]  end_z,
	input  logic                    out_valid,
	input  logic                    out_ready,
	input  logic                    hit,
	input  logic                    truncated,
	input  logic signed [VOX_W-1:0] voxel_x,
	input  logic signed [VOX_W-1:0] voxel_y,
	input  logic signed [VOX_W-1:0] voxel_z,
	input  logic [2:0]              face,
	input  logic signed [FX_W-1:0]  exit_x,
	input  logic signed [FX_W-1:0]  exit_y,
	input  logic signed [FX_W-1:0]  exit_z,
	output int                      errors,
	output int                      outstanding,
	output int                      hit_count,
	output int                      trunc_count
);

	localparam longint FX_MAX = 8388607;
	localparam longint FX_MIN = -8388608;

	typedef struct {
		logic             hit;
		logic             trunc;
		logic [VOX_W-1:0] vox[3];
		logic [2:0]       face;
		logic [FX_W-1:0]  xo[3];
	} ray_result_t;

	bit          occupied[GRID_EDGE*GRID_EDGE*GRID_EDGE];
	ray_result_t expected_hits[$];

	initial begin
		errors = 0;
		hit_count = 0;
		trunc_count = 0;
		foreach (occupied[i]) occupied[i] = 1'b0;
	end

	assign outstanding = expected_hits.size();

	function automatic bit cell_solid(longint c[3]);
		for (int a = 0; a < 3; a++)
			if (c[a] < 0 || c[a] >= GRID_EDGE) return 1'b0;
		return occupied[c[0] + GRID_EDGE * (c[1] + GRID_EDGE * c[2])];
	endfunction

	// rounded to nearest, ties away from zero
	function automatic longint round_div(longint n, longint dv);
		longint an, adv, q;
		an = (n < 0) ? -n : n;
		adv = (dv < 0) ? -dv : dv;
		q = (2 * an + adv) / (2 * adv);
		return ((n < 0) != (dv < 0)) ? -q : q;
	endfunction

	function automatic longint clamp24(longint v);
		if (v > FX_MAX) return FX_MAX;
		if (v < FX_MIN) return FX_MIN;
		return v;
	endfunction

	function automatic ray_result_t trace_ray(longint s[3], longint e[3]);
		ray_result_t r;
		longint d[3], ad[3], num[3], den[3], cur[3], xo[3];
		longint sq, frac, target, nt, m;
		bit pos[3];
		bit l01, l02, l12, got_hit, got_trunc;
		int axis, steps;
		sq = 0;
		axis = 0;
		steps = 0;
		got_hit = 0;
		got_trunc = 0;
		for (int a = 0; a < 3; a++) begin
			d[a] = e[a] - s[a];
			ad[a] = (d[a] < 0) ? -d[a] : d[a];
			sq += ad[a] * ad[a];
			pos[a] = d[a] > 0;
		end
		for (int a = 0; a < 3; a++) begin
			frac = s[a] & 4095;
			cur[a] = s[a] >>> FRAC_W;
			// near-parallel axes never step
			if (sq == 0 || (ad[a] < PAR_LIMIT && (ad[a] * 1000) * (ad[a] * 1000) < sq)) begin
				num[a] = 1;
				den[a] = 1;
			end else begin
				num[a] = pos[a] ? ONE_FX - frac : frac;
				den[a] = ad[a];
			end
		end
		forever begin
			if (num[0] >= den[0] && num[1] >= den[1] && num[2] >= den[2]) break;
			if (steps >= MAX_STEPS) begin
				got_trunc = 1;
				break;
			end
			l01 = num[0] * den[1] < num[1] * den[0];
			l02 = num[0] * den[2] < num[2] * den[0];
			l12 = num[1] * den[2] < num[2] * den[1];
			if (l01) axis = l02 ? 0 : 2;
			else axis = l12 ? 1 : 2;
			cur[axis] += pos[axis] ? 1 : -1;
			num[axis] += ONE_FX;
			steps++;
			if (cell_solid(cur)) begin
				got_hit = 1;
				break;
			end
		end
		for (int a = 0; a < 3; a++) xo[a] = e[a];
		if (got_hit) begin
			target = cur[axis] * ONE_FX + (pos[axis] ? 0 : ONE_FX);
			nt = target - s[axis];
			m = (axis == 1) ? MARGIN_Y : MARGIN_XZ;
			for (int a = 0; a < 3; a++)
				if (a != axis) xo[a] = clamp24(s[a] + round_div(d[a] * nt, d[axis]));
			xo[axis] = clamp24(target - (pos[axis] ? m : -m));
		end
		r.hit = got_hit;
		r.trunc = got_trunc;
		r.face = got_hit ? 3'(axis * 2 + (pos[axis] ? 1 : 0)) : 3'd0;
		for (int a = 0; a < 3; a++) begin
			r.vox[a] = cur[a][VOX_W-1:0];
			r.xo[a] = xo[a][FX_W-1:0];
		end
		return r;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		errors++;
		$display("%0t ns: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
	endtask

	always @(posedge clk) begin
		ray_result_t want;
		longint s[3], e[3];
		if (arst_n && in_valid && in_ready) begin
			if (op == OP_WRITE) begin
				occupied[cell_x + GRID_EDGE * (cell_y + GRID_EDGE * cell_z)] = solid;
			end else begin
				s = '{start_x, start_y, start_z};
				e = '{end_x, end_y, end_z};
				want = trace_ray(s, e);
				expected_hits.push_back(want);
			end
		end
		if (arst_n && out_valid && out_ready) begin
			if (expected_hits.size() == 0) begin
				report_mismatch("unexpected result transaction", 1, 0);
			end else begin
				want = expected_hits.pop_front();
				hit_count += want.hit;
				trunc_count += want.trunc;
				if (hit !== want.hit) report_mismatch("hit", hit, want.hit);
				if (truncated !== want.trunc) report_mismatch("truncated", truncated, want.trunc);
				if (voxel_x !== want.vox[0]) report_mismatch("voxel_x", voxel_x, signed'(want.vox[0]));
				if (voxel_y !== want.vox[1]) report_mismatch("voxel_y", voxel_y, signed'(want.vox[1]));
				if (voxel_z !== want.vox[2]) report_mismatch("voxel_z", voxel_z, signed'(want.vox[2]));
				if (face !== want.face) report_mismatch("face", face, want.face);
				if (exit_x !== want.xo[0]) report_mismatch("exit_x", exit_x, signed'(want.xo[0]));
				if (exit_y !== want.xo[1]) report_mismatch("exit_y", exit_y, signed'(want.xo[1]));
				if (exit_z !== want.xo[2]) report_mismatch("exit_z", exit_z, signed'(want.xo[2]));
			end
		end
	end

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps

// Stimulus and verdict for the voxel ray traversal unit. Scoreboarding lives
// in vrt_checker; this module only feeds transactions and watches for hangs.
module tb import vrt_pkg::*; ();

	localparam int   N_RANDOM = 1000;
	// the clearing pass after reset runs with no accepted transaction
	localparam int   IDLE_LIMIT = 100000;
	localparam int   FX1 = 4096;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    in_valid = 1'b0;
	logic                    in_ready;
	logic                    op = OP_WRITE;
	logic [CELL_W-1:0]       cell_x = '0, cell_y = '0, cell_z = '0;
	logic                    solid = 1'b0;
	logic signed [FX_W-1:0]  start_x = '0, start_y = '0, start_z = '0;
	logic signed [FX_W-1:0]  end_x = '0, end_y = '0, end_z = '0;
	logic                    out_valid;
	logic                    out_ready = 1'b0;
	logic                    hit, truncated;
	logic signed [VOX_W-1:0] voxel_x, voxel_y, voxel_z;
	logic [2:0]              face;
	logic signed [FX_W-1:0]  exit_x, exit_y, exit_z;

	int errors, outstanding, hit_count, trunc_count;
	int idle_cycles = 0;
	int stall_left = 0;
	int n_writes = 0, n_queries = 0;
	bit quiet = 1'b0;   // last stretch: no idling on either side

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	voxel_ray_traversal_unit dut (.*);

	vrt_checker chk (.*);

	// receiver: random stall bursts
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_ready <= 1'b0;
		end else if (!quiet && $urandom_range(0, 5) == 0) begin
			stall_left <= $urandom_range(0, 2);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// watchdog: any accepted transaction on either channel resets the count
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > IDLE_LIMIT) begin
			$display("watchdog expired, %0d results still owed", outstanding);
			$display("TEST FAILED");
			$finish;
		end
	end

	// Present one transaction, with an optional leading gap. Called at a
	// rising edge; returns at the edge where the transaction is accepted.
	task automatic drive_item(logic o, logic [4:0] cx, logic [4:0] cy, logic [4:0] cz,
			logic sd, logic [23:0] s0, logic [23:0] s1, logic [23:0] s2,
			logic [23:0] e0, logic [23:0] e1, logic [23:0] e2);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		op <= o;
		cell_x <= cx;
		cell_y <= cy;
		cell_z <= cz;
		solid <= sd;
		start_x <= s0;
		start_y <= s1;
		start_z <= s2;
		end_x <= e0;
		end_y <= e1;
		end_z <= e2;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		if (o == OP_WRITE) n_writes++;
		else n_queries++;
	endtask

	task automatic put_voxel(int x, int y, int z, bit sd);
		drive_item(OP_WRITE, 5'(x), 5'(y), 5'(z), sd, 24'($urandom), 24'($urandom),
			24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom));
	endtask

	task automatic cast_ray(int s0, int s1, int s2, int e0, int e1, int e2);
		drive_item(OP_QUERY, 5'($urandom), 5'($urandom), 5'($urandom), 1'($urandom),
			24'(s0), 24'(s1), 24'(s2), 24'(e0), 24'(e1), 24'(e2));
	endtask

	// coordinate mostly around the grid, sometimes on a face, sometimes anywhere
	function automatic int pick_coord();
		int k;
		k = $urandom_range(0, 9);
		if (k < 6) return int'($urandom_range(0, 36 * FX1)) - 2 * FX1;
		if (k < 8) return (int'($urandom_range(0, 34)) - 1) * FX1;
		return int'(signed'($urandom_range(0, 24'hFFFFFF) << 8)) >>> 8;
	endfunction

	// endpoint: independent, a short hop (often near-parallel), or anywhere
	function automatic int pick_end(int s);
		int k;
		k = $urandom_range(0, 9);
		if (k < 5) return pick_coord();
		if (k < 7) return s + int'($urandom_range(0, 8)) - 4;
		if (k < 9) return s + int'($urandom_range(0, 16 * FX1)) - 8 * FX1;
		return int'(signed'($urandom_range(0, 24'hFFFFFF) << 8)) >>> 8;
	endfunction

	task automatic random_item();
		int s0, s1, s2;
		if ($urandom_range(0, 9) < 4) begin
			// writes cluster in the grid center so rays there hit often
			if ($urandom_range(0, 4) == 0)
				put_voxel($urandom_range(0, 31), $urandom_range(0, 31),
					$urandom_range(0, 31), 1'($urandom_range(0, 1)));
			else
				put_voxel($urandom_range(10, 21), $urandom_range(10, 21),
					$urandom_range(10, 21), $urandom_range(0, 9) < 6);
		end else begin
			s0 = pick_coord();
			s1 = pick_coord();
			s2 = pick_coord();
			cast_ray(s0, s1, s2, pick_end(s0), pick_end(s1), pick_end(s2));
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: corners of the map, each axis and direction, special cases
		put_voxel(0, 0, 0, 1'b1);
		put_voxel(31, 31, 31, 1'b1);
		put_voxel(16, 5, 5, 1'b1);
		put_voxel(5, 16, 5, 1'b1);
		put_voxel(5, 5, 16, 1'b1);
		put_voxel(31, 31, 31, 1'b0);
		cast_ray(5 * FX1, 5 * FX1, 5 * FX1, 5 * FX1, 5 * FX1, 5 * FX1); // zero length
		cast_ray(2 * FX1 + 100, 5 * FX1 + 2048, 5 * FX1 + 2048, 30 * FX1, 5 * FX1 + 2048,
			5 * FX1 + 2048);                                                  // +x hit
		cast_ray(25 * FX1, 5 * FX1 + 7, 5 * FX1 + 9, 3 * FX1, 5 * FX1 + 7, 5 * FX1 + 9); // -x hit
		cast_ray(5 * FX1 + 1000, 30 * FX1, 5 * FX1 + 3000, 5 * FX1 + 1000, 0, 5 * FX1 + 3000);
		cast_ray(5 * FX1 + 1, 5 * FX1 + 2, 1 * FX1, 5 * FX1 + 3, 5 * FX1 + 4, 28 * FX1);
		cast_ray(4 * FX1, 4 * FX1, 4 * FX1, -FX1, -FX1, -FX1);           // faces, tie, corner
		cast_ray(3 * FX1, 3 * FX1, 3 * FX1, 2, 5 * FX1, 3 * FX1 + 1);    // near-parallel z
		cast_ray(24'h800000, 24'h800000, 24'h800000, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
		cast_ray(24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'h800000);
		cast_ray(-3 * FX1, 40 * FX1, 10, -3 * FX1 + 5, 45 * FX1, 50);    // outside grid
		cast_ray(31 * FX1 + 4095, 31 * FX1 + 4095, 31 * FX1 + 4095, 0, 0, 0); // far corner
		put_voxel(0, 0, 0, 1'b0);

		// hold off until every result is back once, then go random
		in_valid <= 1'b0;
		while (outstanding != 0) @(posedge clk);

		for (int i = 0; i < N_RANDOM; i++) begin
			if (i == N_RANDOM / 2) begin
				in_valid <= 1'b0;
				while (outstanding != 0) @(posedge clk);
			end
			if (i == N_RANDOM - N_RANDOM / 8) quiet = 1'b1;
			random_item();
		end
		in_valid <= 1'b0;

		while (outstanding != 0) @(posedge clk);
		repeat (500) @(posedge clk);

		$display("%0d voxel writes and %0d ray queries: %0d hits, %0d cut at the step limit",
			n_writes, n_queries, hit_count, trunc_count);
		if (errors == 0 && outstanding == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("%0d mismatches, %0d results still owed", errors, outstanding);
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
